// ----- sv/rln_pkg.sv -----
// row layer norm package: sequencer state type and fixed datapath widths
// no dependencies; used by row_layer_norm_top
package rln_pkg;

   localparam int STATE_W = 18;

   // one-hot sequencer states
   typedef enum logic [STATE_W-1:0] {
      ST_IDLE  = 18'h00001,
      ST_VRD   = 18'h00002,
      ST_VDEV  = 18'h00004,
      ST_VSQ   = 18'h00008,
      ST_VACC  = 18'h00010,
      ST_CUBE1 = 18'h00020,
      ST_CUBE2 = 18'h00040,
      ST_DIVV  = 18'h00080,
      ST_SETD  = 18'h00100,
      ST_DIVR  = 18'h00200,
      ST_SQRT  = 18'h00400,
      ST_ORD   = 18'h00800,
      ST_ODEV  = 18'h01000,
      ST_OMUL  = 18'h02000,
      ST_OT    = 18'h04000,
      ST_DIVX  = 18'h08000,
      ST_OY    = 18'h10000,
      ST_ORND  = 18'h20000
   } state_type;

   localparam int VAL_W   = 16;
   localparam int EPS_W   = 24;
   localparam int SUM_W   = 23;
   localparam int DEV_W   = 24;
   localparam int ACC_W   = 51;
   localparam int DEN_W   = 34;
   localparam int XH_W    = 26;
   localparam int NUM_W   = 43;
   localparam logic [EPS_W-1:0] EPS_RESET = 24'd168;

endpackage

// ----- sv/row_layer_norm_top.sv -----
// row layer norm top level: row buffer, sequencer and shared iterative datapath
// depends on rln_pkg
//
// Row-wise layer normalization in signed Q4.12. Elements are taken one per
// cycle while the block is collecting a row; the element flagged row_end, or
// the one that fills the ROW_MAX-entry buffer, closes the row and req_ready
// drops until every result of that row has been handed to the output
// register. Per row of n elements, after the row closes, the block runs a
// variance pass over the buffer, the variance divide, the reciprocal divide
// and the square root, then for each element the output steps and the shared
// shift-subtract divider (skipped when the normalized value clamps), and any
// result may wait for the output register. The divider produces one bit per
// cycle. Results leave through a one-entry output register, so the last
// result of a row may wait while the next row is collected.
module row_layer_norm_top #(
   parameter int ROW_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [rln_pkg::EPS_W-1:0]  csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [15:0]         req_sample,
   input  logic signed [15:0]         req_scale,
   input  logic signed [15:0]         req_offset,
   input  logic                       req_row_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [15:0]         rsp_normed,
   output logic                       rsp_final_of_row,
   output logic                       rsp_clipped
);
   import rln_pkg::*;

   localparam int CW = $clog2(ROW_MAX + 1);
   localparam int AW = $clog2(ROW_MAX);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [EPS_W-1:0] eps_ff;
   logic [3*VAL_W-1:0] rd_ff;
   logic signed [DEV_W-1:0] dev_ff, dev_in;
   logic [47:0] sq_ff, sq_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [15:0] nsq_ff, nsq_in;
   logic [DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [63:0] dv_ff, dv_in, q_ff, q_in;
   logic [5:0] it_ff, it_in;
   logic [62:0] x_ff, x_in, bit_ff, bit_in;
   logic [63:0] res_ff, res_in;
   logic [31:0] r_ff, r_in;
   logic signed [56:0] prod_ff, prod_in;
   logic neg_ff, neg_in;
   logic signed [XH_W-1:0] xh_ff, xh_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_final_ff, rsp_final_in, rsp_clip_ff, rsp_clip_in;
   logic signed [15:0] rsp_normed_ff, rsp_normed_in;

   logic [3*VAL_W-1:0] mem [ROW_MAX];

   logic accept, rd_en, row_done;
   logic [7:0] n8;
   logic signed [8:0] n_s;
   logic signed [15:0] s_s, sc_s, off_s;
   logic signed [24:0] ns_prod;
   logic [23:0] n3_w;
   logic [DEN_W:0] rem_sh;
   logic div_ge;
   logic [DEN_W-1:0] d_w;
   logic [63:0] rb_w, res_step;
   logic [62:0] x_step;
   logic [56:0] mag_w;
   logic [41:0] t_w, lim_w;
   logic [NUM_W-1:0] nmag_w;
   logic [26:0] yq_w;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_normed = rsp_normed_ff;
   assign rsp_final_of_row = rsp_final_ff;
   assign rsp_clipped = rsp_clip_ff;
   assign rd_en = (state_ff == ST_VRD) || (state_ff == ST_ORD);

   // row buffer: one write port, registered read
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[cnt_ff[AW-1:0]] <= {req_sample, req_scale, req_offset};
      end
      if (rd_en) begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // operand views
   assign n8    = 8'(cnt_ff);
   assign n_s   = $signed({1'b0, n8});
   assign s_s   = $signed(rd_ff[47:32]);
   assign sc_s  = $signed(rd_ff[31:16]);
   assign off_s = $signed(rd_ff[15:0]);
   assign ns_prod = n_s * s_s;
   assign n3_w  = nsq_ff * n8;

   // shared shift-subtract divider step
   assign rem_sh = {rem_ff, dv_ff[63]};
   assign div_ge = rem_sh >= {1'b0, den_ff};

   // square root step
   assign rb_w = res_ff + 64'(bit_ff);
   always_comb begin
      if (64'(x_ff) >= rb_w) begin
         x_step   = x_ff - rb_w[62:0];
         res_step = (res_ff >> 1) + 64'(bit_ff);
      end else begin
         x_step   = x_ff;
         res_step = res_ff >> 1;
      end
   end

   // variance floor and output scaling terms
   assign d_w   = q_ff[DEN_W-1:0] + DEN_W'(eps_ff);
   assign mag_w = prod_ff[56] ? 57'(-prod_ff) : 57'(prod_ff);
   assign t_w   = 42'((58'(mag_w) + (58'(n8) << 14)) >> 15);
   assign lim_w = (42'(n8) << 24) + 42'(n8);
   assign nmag_w = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign yq_w  = 27'((44'(nmag_w) + 44'd32768) >> 16);
   assign row_done = (idx_ff + CW'(1)) == cnt_ff;

   // sequencer and datapath next state
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      dev_in = dev_ff;
      sq_in = sq_ff;
      acc_in = acc_ff;
      nsq_in = nsq_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      dv_in = dv_ff;
      q_in = q_ff;
      it_in = it_ff;
      x_in = x_ff;
      bit_in = bit_ff;
      res_in = res_ff;
      r_in = r_ff;
      prod_in = prod_ff;
      neg_in = neg_ff;
      xh_in = xh_ff;
      num_in = num_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_final_in = rsp_final_ff;
      rsp_clip_in = rsp_clip_ff;
      rsp_normed_in = rsp_normed_ff;

      // divider step, used only in the divide states
      if ((state_ff == ST_DIVV) || (state_ff == ST_DIVR) || (state_ff == ST_DIVX)) begin
         rem_in = div_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         dv_in  = dv_ff << 1;
         q_in   = {q_ff[62:0], div_ge};
         it_in  = it_ff - 6'd1;
      end

      case (state_ff)
         // collect row elements
         ST_IDLE: begin
            if (accept) begin
               cnt_in = cnt_ff + CW'(1);
               sum_in = sum_ff + SUM_W'(req_sample);
               if (req_row_end || (cnt_ff + CW'(1)) == CW'(ROW_MAX)) begin
                  state_in = ST_VRD;
                  idx_in = '0;
                  acc_in = '0;
               end
            end
         end
         // variance pass
         ST_VRD:  state_in = ST_VDEV;
         ST_VDEV: begin
            dev_in = DEV_W'(ns_prod - 25'(sum_ff));
            state_in = ST_VSQ;
         end
         ST_VSQ: begin
            sq_in = 48'(dev_ff * dev_ff);
            state_in = ST_VACC;
         end
         ST_VACC: begin
            acc_in = acc_ff + ACC_W'(sq_ff);
            if (row_done) begin
               state_in = ST_CUBE1;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_VRD;
            end
         end
         ST_CUBE1: begin
            nsq_in = n8 * n8;
            state_in = ST_CUBE2;
         end
         // start acc / n^3
         ST_CUBE2: begin
            den_in = DEN_W'(n3_w);
            rem_in = '0;
            dv_in = {acc_ff, 13'd0};
            q_in = '0;
            it_in = 6'd50;
            state_in = ST_DIVV;
         end
         ST_DIVV: begin
            if (it_ff == 6'd0) state_in = ST_SETD;
         end
         // start 2^62 / (var + epsilon)
         ST_SETD: begin
            den_in = (d_w == '0) ? DEN_W'(1) : d_w;
            rem_in = '0;
            dv_in = 64'h8000_0000_0000_0000;
            q_in = '0;
            it_in = 6'd62;
            state_in = ST_DIVR;
         end
         ST_DIVR: begin
            if (it_ff == 6'd0) begin
               x_in = q_in[62:0];
               res_in = '0;
               bit_in = 63'h4000_0000_0000_0000;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            x_in = x_step;
            res_in = res_step;
            bit_in = bit_ff >> 2;
            if (bit_ff == 63'd1) begin
               r_in = res_step[31:0];
               idx_in = '0;
               state_in = ST_ORD;
            end
         end
         // output pass
         ST_ORD:  state_in = ST_ODEV;
         ST_ODEV: begin
            dev_in = DEV_W'(ns_prod - 25'(sum_ff));
            state_in = ST_OMUL;
         end
         ST_OMUL: begin
            prod_in = dev_ff * $signed({1'b0, r_ff});
            state_in = ST_OT;
         end
         ST_OT: begin
            neg_in = prod_ff[56];
            if (t_w >= lim_w) begin
               xh_in = prod_ff[56] ? -26'sd16777216 : 26'sd16777216;
               state_in = ST_OY;
            end else begin
               den_in = DEN_W'(n8);
               rem_in = DEN_W'(t_w >> 25);
               dv_in = {t_w[24:0], 39'd0};
               q_in = '0;
               it_in = 6'd24;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (it_ff == 6'd0) begin
               xh_in = neg_ff ? -$signed(q_in[XH_W-1:0]) : $signed(q_in[XH_W-1:0]);
               state_in = ST_OY;
            end
         end
         ST_OY: begin
            num_in = NUM_W'(sc_s) * NUM_W'(xh_ff) + (NUM_W'(off_s) <<< 16);
            state_in = ST_ORND;
         end
         // round, saturate and hand to the output register
         ST_ORND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_final_in = row_done;
               if (!num_ff[NUM_W-1]) begin
                  rsp_clip_in = yq_w > 27'd32767;
                  rsp_normed_in = rsp_clip_in ? 16'sh7fff : $signed(yq_w[15:0]);
               end else begin
                  rsp_clip_in = yq_w > 27'd32768;
                  rsp_normed_in = rsp_clip_in ? 16'sh8000 : $signed(16'(16'd0 - yq_w[15:0]));
               end
               if (row_done) begin
                  cnt_in = '0;
                  sum_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + CW'(1);
                  state_in = ST_ORD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         sum_ff <= '0;
         eps_ff <= EPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) eps_ff <= csr_wr_data;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      dev_ff <= dev_in;
      sq_ff <= sq_in;
      acc_ff <= acc_in;
      nsq_ff <= nsq_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      dv_ff <= dv_in;
      q_ff <= q_in;
      it_ff <= it_in;
      x_ff <= x_in;
      bit_ff <= bit_in;
      res_ff <= res_in;
      r_ff <= r_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      xh_ff <= xh_in;
      num_ff <= num_in;
      rsp_final_ff <= rsp_final_in;
      rsp_clip_ff <= rsp_clip_in;
      rsp_normed_ff <= rsp_normed_in;
   end

endmodule

// ----- sim/testbench.sv -----
// testbench for row_layer_norm_top: directed table then random rows, checked per result
// depends on rln_pkg and row_layer_norm_top; predictor computes expected rows locally
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rln_pkg::*;

   localparam int ROW_CAP = 64;

   typedef struct {
      logic signed [15:0] sample;
      logic signed [15:0] scale;
      logic signed [15:0] offset;
      logic               row_end;
      logic               has_known;
      logic signed [15:0] known_normed;
      logic               known_clipped;
   } stim_row_type;

   typedef struct {
      logic signed [15:0] normed;
      logic               final_of_row;
      logic               clipped;
   } norm_result_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [EPS_W-1:0] csr_wr_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic signed [15:0] req_sample = '0;
   logic signed [15:0] req_scale = '0;
   logic signed [15:0] req_offset = '0;
   logic req_row_end = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_normed;
   logic rsp_final_of_row;
   logic rsp_clipped;

   row_layer_norm_top #(.ROW_MAX(ROW_CAP)) dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample(req_sample), .req_scale(req_scale),
      .req_offset(req_offset), .req_row_end(req_row_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normed(rsp_normed), .rsp_final_of_row(rsp_final_of_row),
      .rsp_clipped(rsp_clipped)
   );

   always #5 clock = ~clock;

   // predictor state
   logic signed [15:0] buf_sample [ROW_CAP];
   logic signed [15:0] buf_scale  [ROW_CAP];
   logic signed [15:0] buf_offset [ROW_CAP];
   longint      row_sum;
   int          row_count;
   logic [23:0] eps_value;
   norm_result_type expected_q [$];
   // directed known values, one flag per expected result
   logic        known_q_valid [$];
   norm_result_type known_q [$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      begin
         mag = (num < 0) ? -num : num;
         q = (mag + den / 2) / den;
         return (num < 0) ? -q : q;
      end
   endfunction

   function automatic longint int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      begin
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      end
   endfunction

   // buffer one element; on row close push the normalized row
   task automatic predict_norm(input stim_row_type s);
      longint unsigned vsum;
      longint unsigned den;
      longint rstd;
      longint dev;
      longint xh;
      longint y;
      norm_result_type r;
      int n;
      begin
         if (row_count >= ROW_CAP) row_count = 0;
         buf_sample[row_count] = s.sample;
         buf_scale[row_count] = s.scale;
         buf_offset[row_count] = s.offset;
         row_sum += s.sample;
         row_count++;
         if (!s.row_end && row_count < ROW_CAP) return;
         n = row_count;
         vsum = 0;
         for (int j = 0; j < n; j++) begin
            dev = longint'(n) * buf_sample[j] - row_sum;
            vsum += longint'(dev * dev);
         end
         den = vsum / (longint'(n) * n * n) + eps_value;
         if (den == 0) den = 1;
         rstd = int_sqrt((64'd1 << 62) / den);
         for (int j = 0; j < n; j++) begin
            dev = longint'(n) * buf_sample[j] - row_sum;
            xh = round_div(dev * rstd, longint'(n) << 15);
            if (xh > (64'sd1 <<< 24)) xh = 64'sd1 <<< 24;
            if (xh < -(64'sd1 <<< 24)) xh = -(64'sd1 <<< 24);
            y = round_div(longint'(buf_scale[j]) * xh + longint'(buf_offset[j]) * 65536, 65536);
            r.clipped = 0;
            if (y > 32767) begin
               y = 32767; r.clipped = 1;
            end else if (y < -32768) begin
               y = -32768; r.clipped = 1;
            end
            r.normed = y[15:0];
            r.final_of_row = (j + 1 == n);
            expected_q.push_back(r);
         end
         row_sum = 0;
         row_count = 0;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      norm_result_type e;
      norm_result_type k;
      logic kv;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction normed=%0d", rsp_normed);
            error_count++;
         end else begin
            e = expected_q.pop_front();
            kv = 0;
            if (known_q_valid.size() > 0) begin
               kv = known_q_valid.pop_front();
               k = known_q.pop_front();
               if (kv && (k.normed !== e.normed || k.clipped !== e.clipped)) begin
                  $error("table row disagrees: normed exp %0d pred %0d", k.normed, e.normed);
                  error_count++;
               end
            end
            if (rsp_normed !== e.normed) begin
               $error("normed: expected %0d actual %0d", e.normed, rsp_normed);
               error_count++;
            end
            if (rsp_final_of_row !== e.final_of_row) begin
               $error("final_of_row: expected %0d actual %0d", e.final_of_row,
                  rsp_final_of_row);
               error_count++;
            end
            if (rsp_clipped !== e.clipped) begin
               $error("clipped: expected %0d actual %0d", e.clipped, rsp_clipped);
               error_count++;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // valid stays high between back-to-back transactions; dropped only when idling
   task automatic send_element(input stim_row_type s);
      norm_result_type k;
      int before_n;
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 0;
            @(posedge clock);
         end
         req_valid <= 1;
         req_sample <= s.sample;
         req_scale <= s.scale;
         req_offset <= s.offset;
         req_row_end <= s.row_end;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         before_n = expected_q.size();
         predict_norm(s);
         for (int j = before_n; j < expected_q.size(); j++) begin
            known_q_valid.push_back(s.has_known && (j == expected_q.size() - 1));
            k.normed = s.known_normed;
            k.clipped = s.known_clipped;
            k.final_of_row = 1;
            known_q.push_back(k);
         end
      end
   endtask

   task automatic drain_and_write(input logic [EPS_W-1:0] value);
      begin
         req_valid <= 0;
         while (expected_q.size() != 0) @(posedge clock);
         repeat (40) @(posedge clock);
         csr_wr_en <= 1;
         csr_wr_data <= value;
         @(posedge clock);
         csr_wr_en <= 0;
         eps_value = value;
      end
   endtask

   function automatic stim_row_type mk(int s, int g, int o, bit e, bit kv, int kn, bit kc);
      stim_row_type r;
      begin
         r.sample = 16'(s); r.scale = 16'(g); r.offset = 16'(o); r.row_end = e;
         r.has_known = kv; r.known_normed = 16'(kn); r.known_clipped = kc;
         return r;
      end
   endfunction

   function automatic logic signed [15:0] rand_val();
      int pick;
      begin
         pick = $urandom_range(9);
         if (pick == 0) return 16'sh7fff;
         if (pick == 1) return 16'sh8000;
         if (pick < 5) return 16'($urandom_range(8191) - 4096);
         return 16'($urandom);
      end
   endfunction

   // random rows, mostly short with an occasional full buffer
   task automatic random_rows(input int items);
      stim_row_type s;
      int len;
      int left;
      begin
         left = items;
         while (left > 0) begin
            len = ($urandom_range(19) == 0) ? ROW_CAP : $urandom_range(8, 1);
            if (len > left && len != ROW_CAP) len = left;
            for (int j = 0; j < len; j++) begin
               s = mk(rand_val(), rand_val(), rand_val(), 0, 0, 0, 0);
               s.row_end = (j == len - 1) ? (len != ROW_CAP || $urandom_range(1)) : 1'b0;
               send_element(s);
            end
            left -= len;
         end
      end
   endtask

   stim_row_type directed [$];

   initial begin
      row_sum = 0;
      row_count = 0;
      eps_value = EPS_RESET;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // single-element rows give the offset back
      directed.push_back(mk(32767, 32767, 1234, 1, 1, 1234, 0));
      directed.push_back(mk(-32768, -32768, -32768, 1, 1, -32768, 0));
      directed.push_back(mk(0, 0, 32767, 1, 1, 32767, 0));
      // two-element rows at the extremes, saturating then a tie rounded away from zero
      directed.push_back(mk(-32768, 32767, 32767, 0, 0, 0, 0));
      directed.push_back(mk(32767, 32767, 32767, 1, 1, 32767, 1));
      directed.push_back(mk(32767, -32768, -32768, 0, 0, 0, 0));
      directed.push_back(mk(-32768, -32768, -32768, 1, 1, -1, 0));
      // equal samples: zero variance
      directed.push_back(mk(4096, 4096, 100, 0, 0, 0, 0));
      directed.push_back(mk(4096, 4096, 100, 0, 0, 0, 0));
      directed.push_back(mk(4096, 4096, 100, 1, 1, 100, 0));
      // ordinary small row
      directed.push_back(mk(1000, 4096, 0, 0, 0, 0, 0));
      directed.push_back(mk(-2000, 4096, 0, 0, 0, 0, 0));
      directed.push_back(mk(3000, -4096, 512, 0, 0, 0, 0));
      directed.push_back(mk(-500, 8192, -512, 1, 0, 0, 0));
      foreach (directed[i]) send_element(directed[i]);

      // zero epsilon with flat row: divisor floor
      drain_and_write(24'd0);
      send_element(mk(-7, 4096, 5, 0, 0, 0, 0));
      send_element(mk(-7, 4096, 5, 1, 1, 5, 0));
      random_rows(20);

      // largest epsilon, then random rows; a full buffer may close a row with row_end low
      drain_and_write(24'hffffff);
      random_rows(30);
      drain_and_write(EPS_RESET);
      send_idle_pct = 0; recv_stall_pct = 0;
      random_rows(40);
      send_idle_pct = 70; recv_stall_pct = 0;
      random_rows(40);
      drain_and_write(24'($urandom_range(24'hffff)));
      send_idle_pct = 0; recv_stall_pct = 70;
      random_rows(40);
      send_idle_pct = 28; recv_stall_pct = 28;
      random_rows(40);

      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
